@@ rtl/core/bpe_pkg.sv @@
// ----------------------------------------------------------------------------
// bpe_pkg
// Shared types and constants for the bezier point evaluator pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package bpe_pkg;

    // register stages from input capture to output register
    localparam int NUM_STAGES = 8;

    // degree select codes
    localparam logic MODE_QUAD  = 1'b0;
    localparam logic MODE_CUBIC = 1'b1;

    // per-stage load strobes, shared by both coordinate lanes
    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } bpe_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/core/bpe_coef.sv @@
// ----------------------------------------------------------------------------
// bpe_coef
// Converts the control points of one axis into power-basis coefficients
// a0 + a1*t + a2*t^2 + a3*t^3, quadratic terms scaled to the cubic form.
// ----------------------------------------------------------------------------
`default_nettype none

module bpe_coef
    import bpe_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  wire logic                         cubic_mode,
    input  wire logic signed [COORD_BITS-1:0] c0,
    input  wire logic signed [COORD_BITS-1:0] c1,
    input  wire logic signed [COORD_BITS-1:0] c2,
    input  wire logic signed [COORD_BITS-1:0] c3,
    output logic signed [COORD_BITS+3:0]      a0,
    output logic signed [COORD_BITS+3:0]      a1,
    output logic signed [COORD_BITS+3:0]      a2,
    output logic signed [COORD_BITS+3:0]      a3
);

    localparam int AW = COORD_BITS + 4;

    logic signed [AW-1:0] e0;
    logic signed [AW-1:0] e1;
    logic signed [AW-1:0] e2;
    logic signed [AW-1:0] e3;
    logic signed [AW-1:0] d10;
    logic signed [AW-1:0] d2nd;
    logic signed [AW-1:0] d12;

    // sign extension and shared differences
    assign e0   = AW'(c0);
    assign e1   = AW'(c1);
    assign e2   = AW'(c2);
    assign e3   = AW'(c3);
    assign d10  = e1 - e0;
    assign d2nd = e0 - (e1 <<< 1) + e2;
    assign d12  = e1 - e2;

    // coefficients per degree; final values always fit, wrap in between is harmless
    always_comb begin
        a0 = e0;
        unique case (cubic_mode)
            MODE_CUBIC: begin
                a1 = d10 + (d10 <<< 1);
                a2 = d2nd + (d2nd <<< 1);
                a3 = e3 - e0 + d12 + (d12 <<< 1);
            end
            MODE_QUAD: begin
                a1 = d10 <<< 1;
                a2 = d2nd;
                a3 = '0;
            end
            default: begin
                a1 = '0;
                a2 = '0;
                a3 = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/bpe_lane.sv @@
// ----------------------------------------------------------------------------
// bpe_lane
// One coordinate axis: coefficient stage, three Horner multiply/add steps
// over t, each split into a multiply stage and an add stage, and the final
// truncation toward zero into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bpe_lane
    import bpe_pkg::*;
#(
    parameter int COORD_BITS      = 16,
    parameter int PARAM_FRAC_BITS = 16
) (
    input  wire logic                         aclk,
    input  wire bpe_ctrl_t                    ctrl,
    input  wire logic                         cubic_mode,
    input  wire logic signed [COORD_BITS-1:0] c0,
    input  wire logic signed [COORD_BITS-1:0] c1,
    input  wire logic signed [COORD_BITS-1:0] c2,
    input  wire logic signed [COORD_BITS-1:0] c3,
    input  wire logic [PARAM_FRAC_BITS:0]     t_sat,
    output logic signed [COORD_BITS-1:0]      point
);

    localparam int F   = PARAM_FRAC_BITS;
    localparam int AW  = COORD_BITS + 4;
    localparam int TW  = F + 2;
    localparam int H1W = AW + TW;
    localparam int M2W = H1W + TW;
    localparam int M3W = M2W + TW;
    localparam int SH  = 3 * F;
    localparam logic [M3W-1:0] BIAS = {{(M3W-SH){1'b0}}, {SH{1'b1}}};

    logic signed [AW-1:0]  a0_next;
    logic signed [AW-1:0]  a1_next;
    logic signed [AW-1:0]  a2_next;
    logic signed [AW-1:0]  a3_next;
    logic signed [TW-1:0]  t_next;

    logic signed [AW-1:0]  a0_s0_reg, a1_s0_reg, a2_s0_reg, a3_s0_reg;
    logic signed [TW-1:0]  t_s0_reg;
    logic signed [H1W-1:0] p1_s1_reg;
    logic signed [AW-1:0]  a0_s1_reg, a1_s1_reg, a2_s1_reg;
    logic signed [TW-1:0]  t_s1_reg;
    logic signed [H1W-1:0] h1_s2_reg;
    logic signed [AW-1:0]  a0_s2_reg, a1_s2_reg;
    logic signed [TW-1:0]  t_s2_reg;
    logic signed [M2W-1:0] m2_s3_reg;
    logic signed [AW-1:0]  a0_s3_reg, a1_s3_reg;
    logic signed [TW-1:0]  t_s3_reg;
    logic signed [M2W-1:0] h2_s4_reg;
    logic signed [AW-1:0]  a0_s4_reg;
    logic signed [TW-1:0]  t_s4_reg;
    logic signed [M3W-1:0] m3_s5_reg;
    logic signed [AW-1:0]  a0_s5_reg;
    logic signed [M3W-1:0] sum_s6_reg;
    logic [COORD_BITS-1:0] point_reg;

    logic signed [H1W-1:0] p1_next;
    logic signed [H1W-1:0] h1_next;
    logic signed [M2W-1:0] m2_next;
    logic signed [M2W-1:0] h2_next;
    logic signed [M3W-1:0] m3_next;
    logic signed [M3W-1:0] sum_next;
    logic [M3W-1:0]        biased;
    logic [COORD_BITS-1:0] point_next;

    // power-basis coefficients
    bpe_coef #(
        .COORD_BITS (COORD_BITS)
    ) u_coef (
        .cubic_mode (cubic_mode),
        .c0         (c0),
        .c1         (c1),
        .c2         (c2),
        .c3         (c3),
        .a0         (a0_next),
        .a1         (a1_next),
        .a2         (a2_next),
        .a3         (a3_next)
    );

    assign t_next = $signed({1'b0, t_sat});

    // horner steps: ((a3 t + a2 2^F) t + a1 2^2F) t + a0 2^3F
    assign p1_next  = a3_s0_reg * t_s0_reg;
    assign h1_next  = p1_s1_reg + (H1W'(a2_s1_reg) <<< F);
    assign m2_next  = h1_s2_reg * t_s2_reg;
    assign h2_next  = m2_s3_reg + (M2W'(a1_s3_reg) <<< (2 * F));
    assign m3_next  = h2_s4_reg * t_s4_reg;
    assign sum_next = m3_s5_reg + (M3W'(a0_s5_reg) <<< SH);

    // truncate toward zero: bias negative sums before the arithmetic shift
    assign biased     = sum_s6_reg + (sum_s6_reg[M3W-1] ? BIAS : '0);
    assign point_next = biased[SH +: COORD_BITS];

    // stage registers
    always_ff @(posedge aclk) begin
        if (ctrl.load[0]) begin
            a0_s0_reg <= a0_next;
            a1_s0_reg <= a1_next;
            a2_s0_reg <= a2_next;
            a3_s0_reg <= a3_next;
            t_s0_reg  <= t_next;
        end
        if (ctrl.load[1]) begin
            p1_s1_reg <= p1_next;
            a0_s1_reg <= a0_s0_reg;
            a1_s1_reg <= a1_s0_reg;
            a2_s1_reg <= a2_s0_reg;
            t_s1_reg  <= t_s0_reg;
        end
        if (ctrl.load[2]) begin
            h1_s2_reg <= h1_next;
            a0_s2_reg <= a0_s1_reg;
            a1_s2_reg <= a1_s1_reg;
            t_s2_reg  <= t_s1_reg;
        end
        if (ctrl.load[3]) begin
            m2_s3_reg <= m2_next;
            a0_s3_reg <= a0_s2_reg;
            a1_s3_reg <= a1_s2_reg;
            t_s3_reg  <= t_s2_reg;
        end
        if (ctrl.load[4]) begin
            h2_s4_reg <= h2_next;
            a0_s4_reg <= a0_s3_reg;
            t_s4_reg  <= t_s3_reg;
        end
        if (ctrl.load[5]) begin
            m3_s5_reg <= m3_next;
            a0_s5_reg <= a0_s4_reg;
        end
        if (ctrl.load[6]) begin
            sum_s6_reg <= sum_next;
        end
        if (ctrl.load[7]) begin
            point_reg <= point_next;
        end
    end

    assign point = $signed(point_reg);

endmodule

`default_nettype wire

@@ rtl/core/bezier_point_evaluator_unit.sv @@
// ----------------------------------------------------------------------------
// bezier_point_evaluator_unit
// Evaluates one quadratic or cubic bezier point per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one transaction: degree select, four control points and t in
//   unsigned fixed point (2^PARAM_FRAC_BITS is one, larger values clamp to
//   one). m_* returns the point, exact Bernstein sum truncated toward zero.
//   Both channels use valid/ready; a transaction moves when both are high.
//   The datapath is eight register stages (coefficients, three Horner
//   multiply/add pairs, truncation into the output register), and one
//   transaction per clock is sustained while m_ready is high. The multiply
//   stages set the clock rate.
//   When m_ready is low the output holds; stages behind it keep filling any
//   empty slots, so s_ready drops only once every stage is occupied.
//   Synchronous active-low reset empties the pipeline; nothing else needs
//   initialising.
// ----------------------------------------------------------------------------
`default_nettype none

module bezier_point_evaluator_unit
    import bpe_pkg::*;
#(
    parameter int COORD_BITS      = 16,
    parameter int PARAM_FRAC_BITS = 16
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic                         s_cubic_mode,
    input  wire logic signed [COORD_BITS-1:0] s_p0_x,
    input  wire logic signed [COORD_BITS-1:0] s_p0_y,
    input  wire logic signed [COORD_BITS-1:0] s_p1_x,
    input  wire logic signed [COORD_BITS-1:0] s_p1_y,
    input  wire logic signed [COORD_BITS-1:0] s_p2_x,
    input  wire logic signed [COORD_BITS-1:0] s_p2_y,
    input  wire logic signed [COORD_BITS-1:0] s_p3_x,
    input  wire logic signed [COORD_BITS-1:0] s_p3_y,
    input  wire logic [PARAM_FRAC_BITS:0]     s_curve_param,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic signed [COORD_BITS-1:0]      m_point_x,
    output logic signed [COORD_BITS-1:0]      m_point_y
);

    localparam logic [PARAM_FRAC_BITS:0] PARAM_ONE = {1'b1, {PARAM_FRAC_BITS{1'b0}}};

    logic [NUM_STAGES-1:0]  valid_reg;
    logic [NUM_STAGES-1:0]  valid_next;
    logic [NUM_STAGES-1:0]  valid_in;
    logic [NUM_STAGES-1:0]  stage_rdy;
    bpe_ctrl_t              ctrl;
    logic [PARAM_FRAC_BITS:0] t_sat;

    // clamp t to one
    assign t_sat = (s_curve_param > PARAM_ONE) ? PARAM_ONE : s_curve_param;

    // ready ripples back; a stage moves when it is empty or the next one moves
    always_comb begin
        stage_rdy[NUM_STAGES-1] = ~valid_reg[NUM_STAGES-1] | m_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            stage_rdy[k] = ~valid_reg[k] | stage_rdy[k+1];
        end
    end

    // valid bits follow the data
    assign valid_in   = {valid_reg[NUM_STAGES-2:0], s_valid};
    assign valid_next = (stage_rdy & valid_in) | (~stage_rdy & valid_reg);
    assign ctrl.load  = stage_rdy & valid_in;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready = stage_rdy[0];
    assign m_valid = valid_reg[NUM_STAGES-1];

    // x and y lanes
    bpe_lane #(
        .COORD_BITS      (COORD_BITS),
        .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
    ) u_lane_x (
        .aclk       (aclk),
        .ctrl       (ctrl),
        .cubic_mode (s_cubic_mode),
        .c0         (s_p0_x),
        .c1         (s_p1_x),
        .c2         (s_p2_x),
        .c3         (s_p3_x),
        .t_sat      (t_sat),
        .point      (m_point_x)
    );

    bpe_lane #(
        .COORD_BITS      (COORD_BITS),
        .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
    ) u_lane_y (
        .aclk       (aclk),
        .ctrl       (ctrl),
        .cubic_mode (s_cubic_mode),
        .c0         (s_p0_y),
        .c1         (s_p1_y),
        .c2         (s_p2_y),
        .c3         (s_p3_y),
        .t_sat      (t_sat),
        .point      (m_point_y)
    );

    // an accepted transaction lands in the first stage
    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> valid_reg[0])
        else $error("accepted transaction did not enter the pipeline");

    // an empty output register means the whole pipeline can advance
    a_empty_out_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !valid_reg[NUM_STAGES-1] |-> s_ready)
        else $error("input stalled while output register empty");

    // a blocked first stage keeps its transaction
    a_stage0_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[0] && !stage_rdy[0] |=> valid_reg[0])
        else $error("stalled transaction dropped from first stage");

    // a load of the output register leaves a valid transaction in it
    a_load_has_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.load[NUM_STAGES-1] |=> m_valid)
        else $error("output loaded without a valid transaction");

endmodule

`default_nettype wire
